@@ design/rotary_position_rotate_assert.svh @@
// Assertion macros shared by the checker of the rotary position rotation block.
`ifndef ROTARY_POSITION_ROTATE_ASSERT_SVH
`define ROTARY_POSITION_ROTATE_ASSERT_SVH

// Same-cycle implication, switched off while reset is asserted.
`define RPR_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, switched off while reset is asserted.
`define RPR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that is also checked through reset.
`define RPR_ASSERT_RESET(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/rpr_pkg.sv @@
// Types, constants and helper functions of the rotary position rotation block.
package rpr_pkg;

    localparam int MAX_POSITION   = 4096;
    localparam int MAX_HEADS      = 128;
    localparam int MAX_HEAD_WIDTH = 256;

    localparam int CFG_DATA_W = 16;

    typedef enum logic [1:0] {
        CFG_ROTARY_DIMS = 2'd0,
        CFG_HEAD_WIDTH  = 2'd1,
        CFG_HALF_SPLIT  = 2'd2,
        CFG_MAG_SCALE   = 2'd3
    } t_cfg_idx;

    localparam logic [8:0]  RST_ROTARY_DIMS = 9'd128;
    localparam logic [8:0]  RST_HEAD_WIDTH  = 9'd128;
    localparam logic        RST_HALF_SPLIT  = 1'b0;
    localparam logic [15:0] RST_MAG_SCALE   = 16'd16384;

    typedef logic [6:0]         t_head;
    typedef logic [6:0]         t_pair;
    typedef logic [11:0]        t_pos;
    typedef logic [24:0]        t_freq;
    typedef logic signed [15:0] t_q5_10;
    typedef logic [14:0]        t_dest;
    typedef logic [17:0]        t_mag;

    typedef enum logic [1:0] {
        QUAD_0 = 2'd0,
        QUAD_1 = 2'd1,
        QUAD_2 = 2'd2,
        QUAD_3 = 2'd3
    } t_quad;

    // Payload that rides along the trigonometric pipeline untouched.
    typedef struct packed {
        t_dest  first_dest;
        t_dest  second_dest;
        t_q5_10 x_first;
        t_q5_10 x_second;
    } t_side;

    // Scaled sine and cosine magnitudes in Q.16 with the quadrant of the angle.
    typedef struct packed {
        t_mag  sin_mag;
        t_mag  cos_mag;
        t_quad quad;
    } t_trig;

    // Angle constants in Q.32 radians.
    localparam logic [32:0] HALF_PI_Q32    = 33'd6746518852;
    localparam logic [32:0] QUARTER_PI_Q32 = 33'd3373259426;
    // floor(2^46 / (pi/2 in Q.32)), used to estimate the quadrant count.
    localparam logic [13:0] HALF_PI_RECIP  = 14'((64'd1 << 46) / 64'(HALF_PI_Q32));
    localparam logic [30:0] ONE_Q30        = 31'h4000_0000;

    // Rounded-up reciprocals: with shift 30 + ceil(log2 d) the quotient is exact
    // for every 30-bit dividend, so no correction step is needed.
    localparam logic [5:0]  DIV72_SH  = 6'd37;
    localparam logic [31:0] DIV72_MUL = 32'(((64'd1 << 37) + 64'd71) / 64'd72);
    localparam logic [5:0]  DIV42_SH  = 6'd36;
    localparam logic [31:0] DIV42_MUL = 32'(((64'd1 << 36) + 64'd41) / 64'd42);
    localparam logic [5:0]  DIV20_SH  = 6'd35;
    localparam logic [31:0] DIV20_MUL = 32'(((64'd1 << 35) + 64'd19) / 64'd20);
    localparam logic [5:0]  DIV6_SH   = 6'd33;
    localparam logic [31:0] DIV6_MUL  = 32'(((64'd1 << 33) + 64'd5) / 64'd6);
    localparam logic [5:0]  DIV56_SH  = 6'd36;
    localparam logic [31:0] DIV56_MUL = 32'(((64'd1 << 36) + 64'd55) / 64'd56);
    localparam logic [5:0]  DIV30_SH  = 6'd35;
    localparam logic [31:0] DIV30_MUL = 32'(((64'd1 << 35) + 64'd29) / 64'd30);
    localparam logic [5:0]  DIV12_SH  = 6'd34;
    localparam logic [31:0] DIV12_MUL = 32'(((64'd1 << 34) + 64'd11) / 64'd12);

    function automatic logic [29:0] div_const(input logic [29:0] v, input logic [31:0] mul,
                                              input logic [5:0] sh);
        logic [61:0] prod;
        prod = 62'(v) * 62'(mul);
        return 30'(prod >> sh);
    endfunction

    // Q.30 product of a value and a factor of at most one; the result never exceeds a.
    function automatic logic [29:0] mul_q30(input logic [29:0] a, input logic [30:0] b);
        logic [60:0] prod;
        prod = 61'(a) * 61'(b);
        return prod[59:30];
    endfunction

    function automatic t_mag scale_mag(input logic [30:0] m, input logic [15:0] scale);
        logic [47:0] prod;
        prod = 48'(m) * 48'(scale) + (48'd1 << 27);
        return prod[45:28];
    endfunction

    function automatic t_q5_10 round_sat(input logic signed [35:0] v);
        logic signed [35:0] b;
        logic signed [19:0] q;
        b = v + 36'sd32768;
        q = 20'(b >>> 16);
        if (q > 20'sd32767) begin
            return 16'sh7fff;
        end else if (q < -20'sd32768) begin
            return 16'sh8000;
        end
        return q[15:0];
    endfunction

endpackage

@@ design/rpr_in_if.sv @@
// Request channel carrying one element pair and its rotation parameters.
interface rpr_in_if import rpr_pkg::*; ();
    logic   valid;
    logic   ready;
    t_head  head_index;
    t_pair  pair_index;
    t_pos   position;
    t_freq  inv_frequency;
    t_q5_10 x_first;
    t_q5_10 x_second;

    modport source (
        output valid, output head_index, output pair_index, output position,
        output inv_frequency, output x_first, output x_second,
        input  ready
    );
    modport sink (
        input  valid, input head_index, input pair_index, input position,
        input  inv_frequency, input x_first, input x_second,
        output ready
    );
endinterface

@@ design/rpr_out_if.sv @@
// Result channel carrying one rotated pair and its destination indices.
interface rpr_out_if import rpr_pkg::*; ();
    logic   valid;
    logic   ready;
    t_dest  first_dest;
    t_dest  second_dest;
    t_q5_10 y_first;
    t_q5_10 y_second;

    modport source (
        output valid, output first_dest, output second_dest,
        output y_first, output y_second,
        input  ready
    );
    modport sink (
        input  valid, input first_dest, input second_dest,
        input  y_first, input y_second,
        output ready
    );
endinterface

@@ design/rotary_position_rotate.sv @@
// Throughput: one request per cycle while the result side keeps up, set by the 18-stage
// multiplier pipeline of angle reduction, Taylor sine and cosine, scaling and rotation;
// a stalled result holds its segment.
// Reset (synchronous, active low) empties the pipeline and restores the register defaults.
// Register writes take effect at once; there is no clearing pass.
module rotary_position_rotate import rpr_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  t_cfg_idx              i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    rpr_in_if.sink                i_item,
    rpr_out_if.source             o_result
);

    logic [8:0]  r_rotary_dims;
    logic [8:0]  r_head_width;
    logic        r_half_split;
    logic [15:0] r_mag_scale;

    logic [8:0]  hw_eff, rd_eff;
    logic [7:0]  half;
    t_head       head_eff;
    t_pos        pos_eff;
    logic [16:0] base, d0, d1;
    t_side       side;

    logic        sc_ready, sc_valid, rot_ready;
    t_trig       sc_trig;
    t_side       sc_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rotary_dims <= RST_ROTARY_DIMS;
            r_head_width  <= RST_HEAD_WIDTH;
            r_half_split  <= RST_HALF_SPLIT;
            r_mag_scale   <= RST_MAG_SCALE;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ROTARY_DIMS: r_rotary_dims <= i_cfg_data[8:0];
                CFG_HEAD_WIDTH:  r_head_width  <= i_cfg_data[8:0];
                CFG_HALF_SPLIT:  r_half_split  <= i_cfg_data[0];
                CFG_MAG_SCALE:   r_mag_scale   <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Dest indices; user must change registers only while nothing is in flight, unchecked.
    always_comb begin
        hw_eff   = (r_head_width > 9'(MAX_HEAD_WIDTH)) ? 9'(MAX_HEAD_WIDTH) : r_head_width;
        rd_eff   = (r_rotary_dims > hw_eff) ? hw_eff : r_rotary_dims;
        half     = rd_eff[8:1];
        head_eff = 7'(32'(i_item.head_index) % MAX_HEADS);
        pos_eff  = 12'(32'(i_item.position) % MAX_POSITION);
        base     = 17'(head_eff) * 17'(hw_eff);
        if (r_half_split) begin
            d0 = base + 17'(i_item.pair_index);
            d1 = d0 + 17'(half);
        end else begin
            d0 = base + {9'd0, i_item.pair_index, 1'b0};
            d1 = d0 + 17'd1;
        end
        side.first_dest  = d0[14:0];
        side.second_dest = d1[14:0];
        side.x_first     = i_item.x_first;
        side.x_second    = i_item.x_second;
    end

    assign i_item.ready = sc_ready;

    rpr_sincos u_sincos (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_item.valid),
        .o_ready         (sc_ready),
        .i_position      (pos_eff),
        .i_inv_frequency (i_item.inv_frequency),
        .i_side          (side),
        .i_mag_scale     (r_mag_scale),
        .o_valid         (sc_valid),
        .i_ready         (rot_ready),
        .o_trig          (sc_trig),
        .o_side          (sc_side)
    );

    rpr_rotate u_rotate (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (sc_valid),
        .o_ready  (rot_ready),
        .i_trig   (sc_trig),
        .i_side   (sc_side),
        .o_result (o_result)
    );

endmodule

@@ design/rpr_sincos.sv @@
// Sixteen-stage pipeline: angle, reduction to an octant, Taylor sine and cosine, scaling.
module rpr_sincos import rpr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_pos        i_position,
    input  t_freq       i_inv_frequency,
    input  t_side       i_side,
    input  logic [15:0] i_mag_scale,
    output logic        o_valid,
    input  logic        i_ready,
    output t_trig       o_trig,
    output t_side       o_side
);

    localparam int NS = 16;

    logic          adv;
    logic [NS:1]   r_vld;
    t_side         r_side [1:NS];

    logic [36:0]   r_p1;
    logic [12:0]   r_qe2;
    logic [33:0]   r_ang2, r_ang3;
    logic [33:0]   r_qh3;
    logic [33:0]   r_re4;
    logic [32:0]   r_r5;
    logic [1:0]    r_q [3:15];
    logic          r_swap [6:15];
    logic [29:0]   r_t [6:14];
    logic [29:0]   r_u [7:12];
    logic [30:0]   r_sa8, r_ca8, r_sa10, r_ca10, r_sa12, r_ca12, r_sa14;
    logic [29:0]   r_ps9, r_pc9, r_ps11, r_pc11, r_ps13, r_sn15;
    logic [30:0]   r_cs13, r_cs14, r_cs15;
    t_trig         r_trig16;

    logic [36:0]   n_p1;
    logic [38:0]   prod2;
    logic [12:0]   n_qe2;
    logic [45:0]   prod3;
    logic [33:0]   n_re4;
    logic          ge5;
    logic [32:0]   n_r5;
    logic [1:0]    n_q5;
    logic          fold6;
    logic [32:0]   f6;
    logic [29:0]   n_u7;
    logic [30:0]   n_sa8, n_ca8, n_sa10, n_ca10, n_sa12, n_ca12, n_sa14;
    logic [29:0]   n_ps9, n_pc9, n_ps11, n_pc11, n_ps13, n_sn15;
    logic [30:0]   n_cs13;
    logic [30:0]   ms16, mc16;

    // The whole segment moves together; it holds only when its last stage is stuck.
    assign adv     = !r_vld[NS] || i_ready;
    assign o_ready = adv;
    assign o_valid = r_vld[NS];
    assign o_trig  = r_trig16;
    assign o_side  = r_side[NS];

    always_comb begin
        n_p1  = 37'(i_position) * 37'(i_inv_frequency);
        // Quadrant count estimate, at most one short of the true value.
        prod2 = 39'(r_p1[36:12]) * 39'(HALF_PI_RECIP);
        n_qe2 = prod2[38:26];
        prod3 = 46'(r_qe2) * 46'(HALF_PI_Q32);
        // The remainder estimate lies below twice pi/2, so 34 bits suffice.
        n_re4 = r_ang3 - r_qh3;
        ge5   = r_re4 >= 34'(HALF_PI_Q32);
        n_r5  = ge5 ? 33'(r_re4 - 34'(HALF_PI_Q32)) : r_re4[32:0];
        n_q5  = ge5 ? r_q[4] + 2'd1 : r_q[4];
        fold6 = r_r5 > QUARTER_PI_Q32;
        f6    = fold6 ? HALF_PI_Q32 - r_r5 : r_r5;
        n_u7  = mul_q30(r_t[6], 31'(r_t[6]));

        n_sa8  = ONE_Q30 - 31'(div_const(r_u[7], DIV72_MUL, DIV72_SH));
        n_ca8  = ONE_Q30 - 31'(div_const(r_u[7], DIV56_MUL, DIV56_SH));
        n_ps9  = mul_q30(r_u[8], r_sa8);
        n_pc9  = mul_q30(r_u[8], r_ca8);
        n_sa10 = ONE_Q30 - 31'(div_const(r_ps9, DIV42_MUL, DIV42_SH));
        n_ca10 = ONE_Q30 - 31'(div_const(r_pc9, DIV30_MUL, DIV30_SH));
        n_ps11 = mul_q30(r_u[10], r_sa10);
        n_pc11 = mul_q30(r_u[10], r_ca10);
        n_sa12 = ONE_Q30 - 31'(div_const(r_ps11, DIV20_MUL, DIV20_SH));
        n_ca12 = ONE_Q30 - 31'(div_const(r_pc11, DIV12_MUL, DIV12_SH));
        n_ps13 = mul_q30(r_u[12], r_sa12);
        n_cs13 = ONE_Q30 - 31'(mul_q30(r_u[12], r_ca12) >> 1);
        n_sa14 = ONE_Q30 - 31'(div_const(r_ps13, DIV6_MUL, DIV6_SH));
        n_sn15 = mul_q30(r_t[14], r_sa14);

        // Past pi/4 the angle was folded, so sine and cosine trade places.
        ms16 = r_swap[15] ? r_cs15 : 31'(r_sn15);
        mc16 = r_swap[15] ? 31'(r_sn15) : r_cs15;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[NS-1:1], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_side[1] <= i_side;
            for (int k = 2; k <= NS; k++) begin
                r_side[k] <= r_side[k-1];
            end

            r_p1   <= n_p1;
            r_qe2  <= n_qe2;
            r_ang2 <= {r_p1[25:0], 8'd0};
            r_ang3 <= r_ang2;
            r_qh3  <= prod3[33:0];
            r_q[3] <= r_qe2[1:0];
            r_re4  <= n_re4;
            r_q[4] <= r_q[3];
            r_r5   <= n_r5;
            r_q[5] <= n_q5;
            for (int k = 6; k <= 15; k++) begin
                r_q[k] <= r_q[k-1];
            end

            r_swap[6] <= fold6;
            for (int k = 7; k <= 15; k++) begin
                r_swap[k] <= r_swap[k-1];
            end
            r_t[6] <= f6[31:2];
            for (int k = 7; k <= 14; k++) begin
                r_t[k] <= r_t[k-1];
            end
            r_u[7] <= n_u7;
            for (int k = 8; k <= 12; k++) begin
                r_u[k] <= r_u[k-1];
            end

            r_sa8  <= n_sa8;
            r_ca8  <= n_ca8;
            r_ps9  <= n_ps9;
            r_pc9  <= n_pc9;
            r_sa10 <= n_sa10;
            r_ca10 <= n_ca10;
            r_ps11 <= n_ps11;
            r_pc11 <= n_pc11;
            r_sa12 <= n_sa12;
            r_ca12 <= n_ca12;
            r_ps13 <= n_ps13;
            r_cs13 <= n_cs13;
            r_sa14 <= n_sa14;
            r_cs14 <= r_cs13;
            r_sn15 <= n_sn15;
            r_cs15 <= r_cs14;

            r_trig16.sin_mag <= scale_mag(ms16, i_mag_scale);
            r_trig16.cos_mag <= scale_mag(mc16, i_mag_scale);
            r_trig16.quad    <= t_quad'(r_q[15]);
        end
    end

endmodule

@@ design/rpr_rotate.sv @@
// Two-stage rotation of the pair by the signed sine and cosine, with rounding and saturation.
module rpr_rotate import rpr_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  t_trig            i_trig,
    input  t_side            i_side,
    rpr_out_if.source        o_result
);

    logic               adv;
    logic [2:1]         r_vld;
    t_side              r_side_a;
    logic signed [34:0] r_p00, r_p11, r_p01, r_p10;
    t_dest              r_first_dest, r_second_dest;
    t_q5_10             r_y_first, r_y_second;

    logic signed [18:0] sm, cm, s, c;
    logic signed [15:0] x0, x1;
    logic signed [35:0] sum0, sum1;

    assign adv     = !r_vld[2] || o_result.ready;
    assign o_ready = adv;

    always_comb begin
        sm = $signed({1'b0, i_trig.sin_mag});
        cm = $signed({1'b0, i_trig.cos_mag});
        x0 = $signed(i_side.x_first);
        x1 = $signed(i_side.x_second);
        case (i_trig.quad)
            QUAD_0: begin
                s = sm;
                c = cm;
            end
            QUAD_1: begin
                s = cm;
                c = -sm;
            end
            QUAD_2: begin
                s = -sm;
                c = -cm;
            end
            QUAD_3: begin
                s = -cm;
                c = sm;
            end
            default: begin
                s = sm;
                c = cm;
            end
        endcase
        sum0 = 36'(r_p00) - 36'(r_p11);
        sum1 = 36'(r_p01) + 36'(r_p10);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[1], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_p00         <= x0 * c;
            r_p11         <= x1 * s;
            r_p01         <= x0 * s;
            r_p10         <= x1 * c;
            r_side_a      <= i_side;
            r_first_dest  <= r_side_a.first_dest;
            r_second_dest <= r_side_a.second_dest;
            r_y_first     <= round_sat(sum0);
            r_y_second    <= round_sat(sum1);
        end
    end

    assign o_result.valid       = r_vld[2];
    assign o_result.first_dest  = r_first_dest;
    assign o_result.second_dest = r_second_dest;
    assign o_result.y_first     = r_y_first;
    assign o_result.y_second    = r_y_second;

endmodule

@@ design/rpr_checker.sv @@
// Port-level checks of the rotary position rotation block and their binding.
module rpr_checker import rpr_pkg::*; (
    input logic   i_clk,
    input logic   i_rst_n,
    input logic   i_in_valid,
    input logic   i_in_ready,
    input logic   i_out_valid,
    input logic   i_out_ready,
    input t_dest  i_first_dest,
    input t_dest  i_second_dest,
    input t_q5_10 i_y_first,
    input t_q5_10 i_y_second
);

`include "rotary_position_rotate_assert.svh"

    // A result that is not taken stays offered.
    `RPR_ASSERT_NEXT(a_out_held, i_out_valid && !i_out_ready, i_out_valid, "result withdrawn")

    // A stalled result keeps its payload.
    `RPR_ASSERT_NEXT(a_out_stable, i_out_valid && !i_out_ready, $stable(i_first_dest) && $stable(i_second_dest) && $stable(i_y_first) && $stable(i_y_second), "stalled result changed")

    // Reset empties the pipeline.
    `RPR_ASSERT_RESET(a_reset_empty, !i_rst_n, !i_out_valid, "result offered after reset")

    // With nothing waiting at the output every segment can move, so an offered request is taken.
    `RPR_ASSERT_IMPL(a_ready_when_empty, i_in_valid && !i_out_valid, i_in_ready, "request refused while idle")

endmodule

bind rotary_position_rotate rpr_checker u_rpr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_item.valid),
    .i_in_ready    (i_item.ready),
    .i_out_valid   (o_result.valid),
    .i_out_ready   (o_result.ready),
    .i_first_dest  (o_result.first_dest),
    .i_second_dest (o_result.second_dest),
    .i_y_first     (o_result.y_first),
    .i_y_second    (o_result.y_second)
);
